FILE: hw/rtl/smae_pkg.sv
// ============================================================================
// Stack machine executor package
// Shared widths, opcode and status codes, and arithmetic unit types.
// ============================================================================
`default_nettype none

package smae_pkg;

    // Default sizes of the stack
    localparam int STACK_DEPTH_DEF = 512;
    localparam int DATA_WIDTH_DEF  = 32;

    // Field widths of the stream beats
    localparam int OPCODE_W = 5;
    localparam int IMM_W    = 32;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 32;
    localparam int DEPTH_W  = 10;

    // Input beat: opcode [4:0], immediate [36:5], zero pad [39:37]
    localparam int S_OPCODE_LSB = 0;
    localparam int S_IMM_LSB    = S_OPCODE_LSB + OPCODE_W;
    localparam int S_USED_W     = S_IMM_LSB + IMM_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Result beat: status [2:0], value [34:3], value_valid [35],
    // depth [45:36], zero pad [47:46]
    localparam int M_STATUS_LSB = 0;
    localparam int M_VALUE_LSB  = M_STATUS_LSB + STATUS_W;
    localparam int M_VALID_BIT  = M_VALUE_LSB + VALUE_W;
    localparam int M_DEPTH_LSB  = M_VALID_BIT + 1;
    localparam int M_USED_W     = M_DEPTH_LSB + DEPTH_W;
    localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    // Instruction codes
    localparam logic [OPCODE_W-1:0] OP_HLT  = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_NOP  = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_POP  = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_SUB  = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_MUL  = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_DIV  = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_HCF  = 5'd20;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_HALTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FAULT     = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd6;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smae_alu.sv
// ============================================================================
// Stack machine shared arithmetic unit
// One adder/subtractor reused for add, subtract, shift-add multiply and
// restoring signed division, one step per cycle.
// ============================================================================
`default_nettype none

module smae_alu #(
    parameter int DATA_WIDTH = smae_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire smae_pkg::alu_req_t    req,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      result
);
    import smae_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [6:0] {
        A_IDLE = 7'b0000001,
        A_SUM  = 7'b0000010,
        A_MUL  = 7'b0000100,
        A_NEGA = 7'b0001000,
        A_NEGB = 7'b0010000,
        A_DIV  = 7'b0100000,
        A_NEGQ = 7'b1000000
    } alu_state_t;

    alu_state_t            state_reg, state_next;
    alu_op_t               op_reg, op_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] z_reg, z_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  negq_reg, negq_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    logic [DATA_WIDTH:0]   add_x;
    logic [DATA_WIDTH:0]   add_y;
    logic                  add_sub;
    logic [DATA_WIDTH:0]   sum;

    // The single shared adder and its operand selection.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            A_SUM: begin
                add_x   = {1'b0, x_reg};
                add_y   = {1'b0, y_reg};
                add_sub = (op_reg == ALU_SUB);
            end
            A_MUL: begin
                add_x = {1'b0, x_reg};
                add_y = z_reg[0] ? {1'b0, y_reg} : '0;
            end
            A_NEGA, A_NEGQ: begin
                add_y   = {1'b0, z_reg};
                add_sub = 1'b1;
            end
            A_NEGB: begin
                add_y   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            A_DIV: begin
                add_x   = {x_reg, z_reg[DATA_WIDTH-1]};
                add_y   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            default: begin
                add_x = '0;
            end
        endcase
        sum = add_x + (add_y ^ {(DATA_WIDTH + 1){add_sub}})
            + {{DATA_WIDTH{1'b0}}, add_sub};
    end

    // Step sequencer of the unit.
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        cnt_next    = cnt_reg;
        negq_next   = negq_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next   = req.op;
                    cnt_next  = '0;
                    negq_next = operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
                    x_next    = (req.op == ALU_ADD || req.op == ALU_SUB) ? operand_a : '0;
                    y_next    = (req.op == ALU_MUL) ? operand_a : operand_b;
                    z_next    = (req.op == ALU_MUL) ? operand_b : operand_a;
                    case (req.op)
                        ALU_ADD, ALU_SUB: state_next = A_SUM;
                        ALU_MUL:          state_next = A_MUL;
                        default:          state_next = A_NEGA;
                    endcase
                end
            end
            A_SUM: begin
                result_next = sum[DATA_WIDTH-1:0];
                done_next   = 1'b1;
                state_next  = A_IDLE;
            end
            A_MUL: begin
                // Accumulate the multiplicand for each set multiplier bit.
                x_next   = sum[DATA_WIDTH-1:0];
                y_next   = {y_reg[DATA_WIDTH-2:0], 1'b0};
                z_next   = {1'b0, z_reg[DATA_WIDTH-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    result_next = sum[DATA_WIDTH-1:0];
                    done_next   = 1'b1;
                    state_next  = A_IDLE;
                end
            end
            A_NEGA: begin
                if (z_reg[DATA_WIDTH-1]) begin
                    z_next = sum[DATA_WIDTH-1:0];
                end
                state_next = A_NEGB;
            end
            A_NEGB: begin
                if (y_reg[DATA_WIDTH-1]) begin
                    y_next = sum[DATA_WIDTH-1:0];
                end
                state_next = A_DIV;
            end
            A_DIV: begin
                // Restoring division: one quotient bit per cycle.
                if (!sum[DATA_WIDTH]) begin
                    x_next = sum[DATA_WIDTH-1:0];
                    z_next = {z_reg[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    x_next = {x_reg[DATA_WIDTH-2:0], z_reg[DATA_WIDTH-1]};
                    z_next = {z_reg[DATA_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = A_NEGQ;
                end
            end
            A_NEGQ: begin
                result_next = negq_reg ? sum[DATA_WIDTH-1:0] : z_reg;
                done_next   = 1'b1;
                state_next  = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        cnt_reg    <= cnt_next;
        negq_reg   <= negq_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/stack_machine_alu_executor.sv
// ============================================================================
// Stack machine executor
// Runs one stack instruction per input beat and returns one result beat.
// ============================================================================
//
// The slave channel takes one instruction per beat (opcode and immediate).
// Each instruction yields exactly one beat on the master channel with the
// status, the value (popped entry or new top), a value flag and the depth.
// The block holds one instruction at a time; s_tready is low from the
// accepting edge until the result has been handed to the output register.
// States after the accept, before the next accept:
//   halt, fault, nop, push and every error found at decode: decode, done
//   pop: decode, pop, done    divide by zero: decode, read-second, load, done
//   add, sub, mul, div: decode, read-second, load, execute, done; mul takes
//   one multiplier bit per cycle in the shared adder, div takes two magnitude
//   steps, one quotient bit per cycle and one sign step
// Stack reads go through a registered read port, so an operand is used in the state after its read.
// The output register parts the two sides: the next instruction is accepted
// while a result still waits, and it finishes once that result is taken.
// Reset empties the stack, clears the halt flag and drops m_tvalid; stack
// entries above the depth are never read, so the memory itself is not cleared.
//
`default_nettype none

module stack_machine_alu_executor #(
    parameter int STACK_DEPTH = smae_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = smae_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Instruction beats
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // opcode [4:0], immediate [36:5], zero pad [39:37]
    input  wire logic [smae_pkg::S_TDATA_W-1:0] s_tdata,
    // Result beats
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status [2:0], value [34:3], value_valid [35], depth [45:36],
    // zero pad [47:46]
    output logic [smae_pkg::M_TDATA_W-1:0]     m_tdata
);
    import smae_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_POP    = 7'b0000100,
        S_RDSEC  = 7'b0001000,
        S_LOAD   = 7'b0010000,
        S_EXEC   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic [DATA_WIDTH-1:0] imm_reg, imm_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  halted_reg, halted_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_value_reg, res_value_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Stack memory with one write and one registered read port
    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;

    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      cnt_m2;
    logic                  out_free;

    alu_req_t              alu_req;
    logic                  alu_done;
    logic [DATA_WIDTH-1:0] alu_result;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign out_free = !m_tvalid_reg || m_tready;

    smae_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (alu_req),
        .operand_a (rd_data_reg),
        .operand_b (top_reg),
        .done      (alu_done),
        .result    (alu_result)
    );

    // Instruction sequencer.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        imm_next        = imm_reg;
        count_next      = count_reg;
        halted_next     = halted_reg;
        top_next        = top_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_valid_next  = res_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = imm_reg;
        mem_raddr       = cnt_m1[ADDR_W-1:0];
        alu_req.start   = 1'b0;
        alu_req.op      = ALU_ADD;
        case (op_reg)
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            OP_DIV:  alu_req.op = ALU_DIV;
            default: alu_req.op = ALU_ADD;
        endcase

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[S_OPCODE_LSB +: OPCODE_W];
                    imm_next   = DATA_WIDTH'($signed(s_tdata[S_IMM_LSB +: IMM_W]));
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_status_next = STAT_OK;
                res_value_next  = '0;
                res_valid_next  = 1'b0;
                state_next      = S_DONE;
                if (halted_reg) begin
                    res_status_next = STAT_IGNORED;
                end else begin
                    case (op_reg)
                        OP_HLT: begin
                            halted_next     = 1'b1;
                            res_status_next = STAT_HALTED;
                        end
                        OP_HCF: begin
                            halted_next     = 1'b1;
                            res_status_next = STAT_FAULT;
                        end
                        OP_PUSH: begin
                            if (count_reg == CNT_FULL) begin
                                res_status_next = STAT_OVERFLOW;
                            end else begin
                                mem_we         = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                                res_value_next = imm_reg;
                                res_valid_next = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_UNDERFLOW;
                            end else begin
                                state_next = S_POP;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (count_reg < CNT_W'(2)) begin
                                res_status_next = STAT_UNDERFLOW;
                            end else begin
                                state_next = S_RDSEC;
                            end
                        end
                        default: begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_POP: begin
                count_next     = cnt_m1;
                res_value_next = rd_data_reg;
                res_valid_next = 1'b1;
                state_next     = S_DONE;
            end
            S_RDSEC: begin
                // Top entry arrives; fetch the one below it.
                top_next   = rd_data_reg;
                mem_raddr  = cnt_m2[ADDR_W-1:0];
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (op_reg == OP_DIV && top_reg == '0) begin
                    res_status_next = STAT_DIVZERO;
                    state_next      = S_DONE;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (alu_done) begin
                    mem_we         = 1'b1;
                    mem_waddr      = cnt_m2[ADDR_W-1:0];
                    mem_wdata      = alu_result;
                    count_next     = cnt_m1;
                    res_value_next = alu_result;
                    res_valid_next = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({
                        DEPTH_W'(count_reg),
                        res_valid_reg,
                        VALUE_W'(res_value_reg),
                        res_status_reg
                    });
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            halted_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            halted_reg   <= halted_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        imm_reg        <= imm_next;
        top_reg        <= top_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_valid_reg  <= res_valid_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Stack memory ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/smae_checker.sv
// ============================================================================
// Stack machine executor port checker
// Watches the stream ports of the executor and flags illegal behavior.
// ============================================================================
`default_nettype none

module smae_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [smae_pkg::M_TDATA_W-1:0]  m_tdata
);
    import smae_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic [VALUE_W-1:0]  out_value;
    logic                out_valid;

    assign out_status = m_tdata[M_STATUS_LSB +: STATUS_W];
    assign out_value  = m_tdata[M_VALUE_LSB +: VALUE_W];
    assign out_valid  = m_tdata[M_VALID_BIT];

    // A stalled result beat stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    // The block works on one instruction at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("instruction accepted while another is being executed");

    // Without a meaningful value the value field reads zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_valid |-> out_value == '0)
    else $error("value field not zero when flagged as meaningless");

    // Only a successful instruction carries a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_valid |-> out_status == STAT_OK)
    else $error("value flagged on a result that is not ok");

    // Status codes stay within the defined set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_status <= STAT_IGNORED)
    else $error("undefined status code on result beat");

endmodule

bind stack_machine_alu_executor smae_checker u_smae_checker (.*);

`default_nettype wire

FILE: tb/tb_stack_machine_alu_executor.sv
// ============================================================================
// Stack machine executor testbench
// Drives instruction beats into the executor and checks every result beat
// against a cycle-free model of the stack kept in the testbench. A short
// table of directed instructions comes first. Random programs follow, with
// one run that fills the stack to overflow. A single halt closes the run.
// ============================================================================

module tb_stack_machine_alu_executor;

    import smae_pkg::*;

    // Opcodes with no defined meaning; the block treats them as no-ops
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 5'd19;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 5'd31;

    localparam int DIR_N       = 25;
    localparam int RAND_N      = 1300;
    localparam int FILL_AT     = 200;
    localparam int CALM_FROM   = 800;
    localparam int CALM_TO     = 1000;
    localparam int DRAIN_CYC   = 64;
    localparam int STALL_LIMIT = 4000;

    // One result beat, unpacked
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic                value_valid;
        logic [DEPTH_W-1:0]  depth;
    } exec_result_t;

    // One row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [IMM_W-1:0]    imm;
        logic                typed;
        exec_result_t        res;
    } stim_row_t;

    localparam exec_result_t NO_RES = '0;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Stack model
    logic [DATA_WIDTH_DEF-1:0] stk_mem [STACK_DEPTH_DEF];
    int                        stk_cnt  = 0;
    logic                      halted_q = 1'b0;

    exec_result_t pending_results [$];
    stim_row_t    dir_tab [DIR_N];
    int           err_cnt  = 0;
    int           idle_cyc = 0;
    bit           calm     = 1'b0;

    stack_machine_alu_executor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Executes one instruction on the stack model and returns its result.
    function automatic exec_result_t exec_instr(input logic [OPCODE_W-1:0] op,
                                                input logic [IMM_W-1:0] imm);
        exec_result_t r;
        logic [DATA_WIDTH_DEF-1:0] tos, nos, mag_a, mag_b, acc;
        r = '0;
        if (halted_q) begin
            r.status = STAT_IGNORED;
        end else begin
            case (op)
                OP_HLT: begin
                    halted_q = 1'b1;
                    r.status = STAT_HALTED;
                end
                OP_HCF: begin
                    halted_q = 1'b1;
                    r.status = STAT_FAULT;
                end
                OP_PUSH: begin
                    if (stk_cnt >= STACK_DEPTH_DEF) begin
                        r.status = STAT_OVERFLOW;
                    end else begin
                        stk_mem[stk_cnt] = imm;
                        stk_cnt++;
                        r.value       = imm;
                        r.value_valid = 1'b1;
                    end
                end
                OP_POP: begin
                    if (stk_cnt == 0) begin
                        r.status = STAT_UNDERFLOW;
                    end else begin
                        stk_cnt--;
                        r.value       = stk_mem[stk_cnt];
                        r.value_valid = 1'b1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (stk_cnt < 2) begin
                        r.status = STAT_UNDERFLOW;
                    end else begin
                        tos = stk_mem[stk_cnt-1];
                        nos = stk_mem[stk_cnt-2];
                        if (op == OP_DIV && tos == '0) begin
                            r.status = STAT_DIVZERO;
                        end else begin
                            case (op)
                                OP_ADD: acc = nos + tos;
                                OP_SUB: acc = nos - tos;
                                OP_MUL: acc = nos * tos;
                                default: begin
                                    // Divide magnitudes, then restore the sign;
                                    // the most negative value over -1 wraps.
                                    mag_a = nos[DATA_WIDTH_DEF-1] ? -nos : nos;
                                    mag_b = tos[DATA_WIDTH_DEF-1] ? -tos : tos;
                                    acc   = mag_a / mag_b;
                                    if (nos[DATA_WIDTH_DEF-1] ^ tos[DATA_WIDTH_DEF-1]) begin
                                        acc = -acc;
                                    end
                                end
                            endcase
                            stk_cnt--;
                            stk_mem[stk_cnt-1] = acc;
                            r.value       = acc;
                            r.value_valid = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.depth = stk_cnt[DEPTH_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Presents one instruction beat, waits for its acceptance and records
    // the result it should produce.
    task automatic send_instr(input logic [OPCODE_W-1:0] op, input logic [IMM_W-1:0] imm,
                              input logic typed, input exec_result_t typed_res);
        logic [S_TDATA_W-1:0] beat;
        exec_result_t         res;
        while (!calm && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        beat = '0;
        beat[S_OPCODE_LSB +: OPCODE_W] = op;
        beat[S_IMM_LSB +: IMM_W]       = imm;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = exec_instr(op, imm);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Result side stalls at random, except in the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 17);
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        exec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status),
                            32'(m_tdata[M_STATUS_LSB +: STATUS_W]));
                check_field("value", want.value, m_tdata[M_VALUE_LSB +: VALUE_W]);
                check_field("value_valid", 32'(want.value_valid),
                            32'(m_tdata[M_VALID_BIT]));
                check_field("depth", 32'(want.depth),
                            32'(m_tdata[M_DEPTH_LSB +: DEPTH_W]));
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cyc <= 0;
            end else begin
                idle_cyc <= idle_cyc + 1;
            end
            if (idle_cyc >= STALL_LIMIT) begin
                $display("tb_stack_machine_alu_executor: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [OPCODE_W-1:0] op;
        logic [OPCODE_W-1:0] stop_op;
        logic [IMM_W-1:0]    imm;
        int                  roll;
        int                  push_pct;
        int                  ovf_left;
        bit                  filling;

        // Directed program: empty-stack errors, extremes, divide by zero,
        // the wrapping quotient, every arithmetic op and spare opcodes.
        dir_tab = '{
            {OP_POP,       32'h0000_0000, 1'b1, STAT_UNDERFLOW, 32'h0, 1'b0, 10'd0},
            {OP_ADD,       32'hFFFF_FFFF, 1'b1, STAT_UNDERFLOW, 32'h0, 1'b0, 10'd0},
            {OP_PUSH,      32'h7FFF_FFFF, 1'b1, STAT_OK, 32'h7FFF_FFFF, 1'b1, 10'd1},
            {OP_MUL,       32'h0000_0000, 1'b1, STAT_UNDERFLOW, 32'h0, 1'b0, 10'd1},
            {OP_PUSH,      32'h8000_0000, 1'b1, STAT_OK, 32'h8000_0000, 1'b1, 10'd2},
            {OP_ADD,       32'h1234_5678, 1'b0, NO_RES},
            {OP_PUSH,      32'h0000_0000, 1'b0, NO_RES},
            {OP_DIV,       32'h0000_0000, 1'b1, STAT_DIVZERO, 32'h0, 1'b0, 10'd2},
            {OP_POP,       32'h0000_0000, 1'b0, NO_RES},
            {OP_PUSH,      32'h8000_0000, 1'b0, NO_RES},
            {OP_PUSH,      32'hFFFF_FFFF, 1'b0, NO_RES},
            {OP_DIV,       32'h0000_0000, 1'b1, STAT_OK, 32'h8000_0000, 1'b1, 10'd2},
            {OP_PUSH,      32'h0000_0007, 1'b0, NO_RES},
            {OP_SUB,       32'h0000_0000, 1'b0, NO_RES},
            {OP_PUSH,      32'hFFFF_FFFD, 1'b0, NO_RES},
            {OP_MUL,       32'h0000_0000, 1'b0, NO_RES},
            {OP_PUSH,      32'h0000_0002, 1'b0, NO_RES},
            {OP_DIV,       32'h0000_0000, 1'b0, NO_RES},
            {OP_NOP,       32'hFFFF_FFFF, 1'b1, STAT_OK, 32'h0, 1'b0, 10'd2},
            {OP_SPARE_LO,  32'h0000_0000, 1'b1, STAT_OK, 32'h0, 1'b0, 10'd2},
            {OP_SPARE_MID, 32'hAAAA_5555, 1'b0, NO_RES},
            {OP_SPARE_HI,  32'h5555_AAAA, 1'b0, NO_RES},
            {OP_POP,       32'h0000_0000, 1'b0, NO_RES},
            {OP_POP,       32'h0000_0000, 1'b0, NO_RES},
            {OP_POP,       32'h0000_0000, 1'b1, STAT_UNDERFLOW, 32'h0, 1'b0, 10'd0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            send_instr(dir_tab[i].op, dir_tab[i].imm, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random programs. Push odds follow the depth so the stack wanders
        // up and down; one run pushes to full and then past it.
        filling  = 1'b0;
        ovf_left = 3;
        for (int i = 0; i < RAND_N; i++) begin
            calm = (i >= CALM_FROM && i < CALM_TO);
            if (i == FILL_AT) begin
                filling = 1'b1;
            end

            case ($urandom_range(0, 7))
                0:       imm = 32'h0000_0000;
                1:       imm = 32'h8000_0000;
                2:       imm = 32'h7FFF_FFFF;
                3:       imm = 32'hFFFF_FFFF;
                4, 5:    imm = $urandom_range(0, 16) - 8;
                default: imm = $urandom;
            endcase

            push_pct = (stk_cnt < 4) ? 60 : ((stk_cnt > 40) ? 15 : 35);
            roll     = $urandom_range(0, 99);
            if (filling) begin
                op = OP_PUSH;
                if (stk_cnt >= STACK_DEPTH_DEF) begin
                    ovf_left--;
                    if (ovf_left == 0) begin
                        filling = 1'b0;
                    end
                end
            end else if (roll < push_pct) begin
                op = OP_PUSH;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 18) begin
                    op = OP_POP;
                end else if (roll < 90) begin
                    op = OP_ADD + OPCODE_W'($urandom_range(0, 3));
                end else begin
                    // Any code that neither halts nor touches the stack
                    do begin
                        op = OPCODE_W'($urandom_range(0, 31));
                    end while (op == OP_HLT || op == OP_HCF ||
                               (op >= OP_PUSH && op <= OP_DIV));
                end
            end
            send_instr(op, imm, 1'b0, NO_RES);
        end
        calm = 1'b0;

        // A halt can happen only once per reset, so the seed picks which
        // stop code ends the run; the other one then meets a halted block.
        stop_op = $urandom_range(0, 1) ? OP_HCF : OP_HLT;
        send_instr(stop_op, $urandom, 1'b0, NO_RES);
        send_instr((stop_op == OP_HLT) ? OP_HCF : OP_HLT, $urandom, 1'b0, NO_RES);
        send_instr(OP_PUSH, $urandom, 1'b0, NO_RES);
        send_instr(OP_POP, $urandom, 1'b0, NO_RES);
        send_instr(OP_DIV, $urandom, 1'b0, NO_RES);
        for (int k = 0; k < 4; k++) begin
            send_instr(OPCODE_W'($urandom_range(0, 31)), $urandom, 1'b0, NO_RES);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_stack_machine_alu_executor: done, clean");
        end else begin
            $display("tb_stack_machine_alu_executor: done, errors");
        end
        $finish;
    end

endmodule
